// ===== design/ght_pkg.sv =====
package ght_pkg;

  localparam int SLOT_COUNT = 64;
  localparam int IDX_W      = $clog2(SLOT_COUNT);
  localparam int CNT_W      = IDX_W + 1;

  localparam logic [1:0] CMD_REGISTER   = 2'd0;
  localparam logic [1:0] CMD_UNREGISTER = 2'd1;
  localparam logic [1:0] CMD_LOOKUP     = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  localparam logic [31:0] FRESH_GEN = 32'd1;

  typedef logic [IDX_W-1:0] slot_idx_t;
  typedef logic [CNT_W-1:0] slot_cnt_t;

  typedef struct packed {
    logic [31:0] generation;
    logic [31:0] callback;
    logic [31:0] user;
  } slot_t;

  typedef struct packed {
    logic      rd;
    logic      push;
    logic      pop;
    slot_idx_t push_idx;
  } stack_ctl_t;

endpackage

// ===== design/ght_free_stack.sv =====
module ght_free_stack
  import ght_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  stack_ctl_t ctl,
  output slot_idx_t  top,
  output slot_cnt_t  count
);

  slot_idx_t mem [SLOT_COUNT];
  slot_idx_t top_addr;

  // The read returns the entry just below the count, the next one to pop.
  assign top_addr = slot_idx_t'(count - slot_cnt_t'(1));

  always_ff @(posedge clk) begin
    if (ctl.rd) begin
      top <= mem[top_addr];
    end
    if (ctl.push) begin
      mem[count[IDX_W-1:0]] <= ctl.push_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctl.push && count < slot_cnt_t'(SLOT_COUNT)) begin
      count <= count + slot_cnt_t'(1);
    end else if (ctl.pop && count != '0) begin
      count <= count - slot_cnt_t'(1);
    end
  end

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    ctl.pop |-> count != '0)
    else $error("pop from an empty free stack");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    ctl.push |-> count < slot_cnt_t'(SLOT_COUNT))
    else $error("push onto a full free stack");

  a_push_pop_excl: assert property (@(posedge clk) disable iff (rst)
    !(ctl.push && ctl.pop))
    else $error("push and pop in the same cycle");

endmodule

// ===== design/generational_handle_table.sv =====
// Channel  | handshake            | payload
// ---------+----------------------+-------------------------------------------------------------
// input    | in_valid, in_stall   | command, handle_index, handle_generation, callback_ref, user_word
// output   | out_valid, out_stall | status, out_index, out_generation, found_callback, found_user_word
//
// A request goes from idle to evaluate; a register that reuses a freed slot adds an execute
// state, since the free stack read must finish before the slot memory can be read.
// One request is in flight at a time; the result sits in an output register,
// so a new request is taken while the previous result waits.
// Synchronous reset empties the table at once; there is no clearing pass.
// A stalled output holds the finished request in its last state until taken.
module generational_handle_table
  import ght_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  command,
  input  logic [31:0] handle_index,
  input  logic [31:0] handle_generation,
  input  logic [31:0] callback_ref,
  input  logic [31:0] user_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [31:0] out_index,
  output logic [31:0] out_generation,
  output logic [31:0] found_callback,
  output logic [31:0] found_user_word
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EVAL = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;

  logic [1:0]  state, state_next;
  logic [1:0]  cmd_q;
  logic [31:0] hidx_q, hgen_q, cb_q, uw_q;
  slot_cnt_t   used;
  slot_idx_t   exec_idx;

  slot_t       slot_mem [SLOT_COUNT];
  slot_t       slot_q;
  logic        slot_rd;
  slot_idx_t   slot_ra;
  logic        slot_we;
  slot_idx_t   slot_wa;
  slot_t       slot_wd;

  stack_ctl_t  sctl;
  slot_idx_t   stack_top;
  slot_cnt_t   free_depth;

  logic        accept, out_free, done, go, handle_ok, bump_used;
  logic [1:0]  res_status;
  logic [31:0] res_index, res_gen, res_cb, res_uw;

  ght_free_stack u_stack (
    .clk   (clk),
    .rst   (rst),
    .ctl   (sctl),
    .top   (stack_top),
    .count (free_depth)
  );

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign go       = done && out_free;

  // Every slot below the used mark has been written at least once, so the
  // memory needs no valid bits: a handle past the mark is rejected before
  // its data matters.
  assign handle_ok = !(hidx_q == '0 && hgen_q == '0)
                  && (hidx_q < 32'(used))
                  && (slot_q.generation == hgen_q)
                  && (slot_q.callback != '0);

  always_comb begin
    state_next = state;
    done       = 1'b0;
    bump_used  = 1'b0;
    slot_rd    = 1'b0;
    slot_ra    = handle_index[IDX_W-1:0];
    slot_we    = 1'b0;
    slot_wa    = hidx_q[IDX_W-1:0];
    slot_wd    = '0;
    sctl       = '0;
    sctl.push_idx = hidx_q[IDX_W-1:0];
    res_status = ST_NOT_FOUND;
    res_index  = '0;
    res_gen    = '0;
    res_cb     = '0;
    res_uw     = '0;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          slot_rd    = 1'b1;
          sctl.rd    = 1'b1;
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        unique case (cmd_q)
          CMD_REGISTER: begin
            if (cb_q == '0) begin
              done       = 1'b1;
              res_status = ST_NULL;
            end else if (free_depth != '0) begin
              // Reuse the most recently freed slot: fetch it, then finish.
              slot_rd    = 1'b1;
              slot_ra    = stack_top;
              sctl.pop   = 1'b1;
              state_next = S_EXEC;
            end else if (used < slot_cnt_t'(SLOT_COUNT)) begin
              done       = 1'b1;
              bump_used  = go;
              slot_we    = go;
              slot_wa    = used[IDX_W-1:0];
              slot_wd    = '{generation: FRESH_GEN, callback: cb_q, user: uw_q};
              res_status = ST_OK;
              res_index  = 32'(used[IDX_W-1:0]);
              res_gen    = FRESH_GEN;
            end else begin
              done       = 1'b1;
              res_status = ST_FULL;
            end
          end
          CMD_UNREGISTER: begin
            done = 1'b1;
            if (handle_ok) begin
              slot_we    = go;
              slot_wd    = '{generation: slot_q.generation + 32'd1,
                             callback: '0, user: '0};
              sctl.push  = go;
              res_status = ST_OK;
            end
          end
          CMD_LOOKUP: begin
            done = 1'b1;
            if (handle_ok) begin
              res_status = ST_OK;
              res_cb     = slot_q.callback;
              res_uw     = slot_q.user;
            end
          end
          default: begin
            done = 1'b1;
          end
        endcase
        if (go) begin
          state_next = S_IDLE;
        end
      end
      S_EXEC: begin
        done       = 1'b1;
        slot_we    = go;
        slot_wa    = exec_idx;
        slot_wd    = '{generation: slot_q.generation, callback: cb_q, user: uw_q};
        res_status = ST_OK;
        res_index  = 32'(exec_idx);
        res_gen    = slot_q.generation;
        if (go) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (slot_rd) begin
      slot_q <= slot_mem[slot_ra];
    end
    if (slot_we) begin
      slot_mem[slot_wa] <= slot_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q  <= command;
      hidx_q <= handle_index;
      hgen_q <= handle_generation;
      cb_q   <= callback_ref;
      uw_q   <= user_word;
    end
    if (state == S_EVAL) begin
      exec_idx <= stack_top;
    end
    if (go) begin
      status          <= res_status;
      out_index       <= res_index;
      out_generation  <= res_gen;
      found_callback  <= res_cb;
      found_user_word <= res_uw;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      used      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (bump_used) begin
        used <= used + slot_cnt_t'(1);
      end
      if (go) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_free_le_used: assert property (@(posedge clk) disable iff (rst)
    free_depth <= used)
    else $error("more free slots than slots ever used");

  a_used_monotonic: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> used >= $past(used))
    else $error("used mark went backwards");

  a_write_when_done: assert property (@(posedge clk) disable iff (rst)
    slot_we |-> go && (state == S_EVAL || state == S_EXEC))
    else $error("slot write outside a finishing request");

  a_go_shows_result: assert property (@(posedge clk) disable iff (rst)
    go |=> out_valid && state == S_IDLE)
    else $error("finished request did not reach the output");

endmodule

// ===== tb/generational_handle_table_tb.sv =====
`timescale 1ns / 1ps

module generational_handle_table_tb
  import ght_pkg::*;
;

  localparam logic [1:0] CMD_UNDEFINED = 2'd3;
  localparam int RANDOM_REQUESTS = 500;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] index;
    logic [31:0] generation;
    logic [31:0] callback;
    logic [31:0] user;
  } reply_t;

  typedef enum logic [1:0] {FLOW, LIGHT, HEAVY, PERIODIC} stall_mode_t;

  // Tracks the table contents as each request is accepted and keeps the
  // replies still owed by the block, oldest first.
  class handle_table_tracker;
    bit [31:0]   gen_of      [SLOT_COUNT];
    bit [31:0]   callback_of [SLOT_COUNT];
    bit [31:0]   user_of     [SLOT_COUNT];
    int unsigned free_slots  [SLOT_COUNT];
    int unsigned free_depth;
    int unsigned ever_used;
    reply_t      replies_due [$];
    int          errors;

    function new();
      for (int s = 0; s < SLOT_COUNT; s++) begin
        gen_of[s]      = FRESH_GEN;
        callback_of[s] = '0;
        user_of[s]     = '0;
        free_slots[s]  = 0;
      end
      free_depth = 0;
      ever_used  = 0;
      errors     = 0;
    endfunction

    task report_mismatch(string msg);
      $display("mismatch at %0t ns: %s", $time, msg);
      errors++;
    endtask

    function bit handle_live(logic [31:0] idx, logic [31:0] gen);
      if (idx == '0 && gen == '0) return 1'b0;
      if (idx >= ever_used) return 1'b0;
      if (gen_of[idx] != gen) return 1'b0;
      return callback_of[idx] != '0;
    endfunction

    function bit pick_live(output int slot);
      int live [$];
      slot = 0;
      for (int s = 0; s < ever_used; s++)
        if (callback_of[s] != '0) live.insert(live.size(), s);
      if (live.size() == 0) return 1'b0;
      slot = live[$urandom_range(live.size() - 1)];
      return 1'b1;
    endfunction

    function void take_request(logic [1:0] cmd, logic [31:0] idx, logic [31:0] gen,
                               logic [31:0] cb, logic [31:0] uw);
      reply_t r;
      int     slot;
      bit     granted;
      r = '0;
      r.status = ST_NOT_FOUND;
      granted = 1'b0;
      slot = 0;
      case (cmd)
        CMD_REGISTER: begin
          // A null callback is refused before fullness is considered.
          if (cb == '0) begin
            r.status = ST_NULL;
          end else if (free_depth > 0) begin
            free_depth--;
            slot = free_slots[free_depth];
            granted = 1'b1;
          end else if (ever_used < SLOT_COUNT) begin
            slot = ever_used;
            ever_used++;
            granted = 1'b1;
          end else begin
            r.status = ST_FULL;
          end
          if (granted) begin
            callback_of[slot] = cb;
            user_of[slot]     = uw;
            r.status     = ST_OK;
            r.index      = slot;
            r.generation = gen_of[slot];
          end
        end
        CMD_UNREGISTER: begin
          if (handle_live(idx, gen)) begin
            callback_of[idx] = '0;
            user_of[idx]     = '0;
            gen_of[idx]      = gen_of[idx] + 32'd1;
            free_slots[free_depth] = idx;
            free_depth++;
            r.status = ST_OK;
          end
        end
        CMD_LOOKUP: begin
          if (handle_live(idx, gen)) begin
            r.status   = ST_OK;
            r.callback = callback_of[idx];
            r.user     = user_of[idx];
          end
        end
        default: ;
      endcase
      replies_due.insert(replies_due.size(), r);
    endfunction

    task compare_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
        report_mismatch($sformatf("%s is %h, expected %h", name, got, want));
    endtask

    task check_reply(reply_t got);
      reply_t want;
      if (replies_due.size() == 0) begin
        report_mismatch("reply arrived with no request outstanding");
        return;
      end
      want = replies_due[0];
      replies_due.delete(0);
      compare_field("status", 32'(got.status), 32'(want.status));
      compare_field("out_index", got.index, want.index);
      compare_field("out_generation", got.generation, want.generation);
      compare_field("found_callback", got.callback, want.callback);
      compare_field("found_user_word", got.user, want.user);
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  command = CMD_LOOKUP;
  logic [31:0] handle_index = '0;
  logic [31:0] handle_generation = '0;
  logic [31:0] callback_ref = '0;
  logic [31:0] user_word = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  status;
  logic [31:0] out_index;
  logic [31:0] out_generation;
  logic [31:0] found_callback;
  logic [31:0] found_user_word;

  handle_table_tracker sb = new();
  int burst_left = 0;

  generational_handle_table i_dut (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .command           (command),
    .handle_index      (handle_index),
    .handle_generation (handle_generation),
    .callback_ref      (callback_ref),
    .user_word         (user_word),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .status            (status),
    .out_index         (out_index),
    .out_generation    (out_generation),
    .found_callback    (found_callback),
    .found_user_word   (found_user_word)
  );

  always #1 clk = ~clk;

  // The receiver changes its mood every so often: free flowing, light or heavy
  // random back-pressure, or a fixed periodic stall.
  stall_mode_t stall_mode = FLOW;
  int          stall_left = 0;

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= stall_mode_t'($urandom_range(3));
      stall_left <= $urandom_range(30, 150);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      FLOW:    out_stall <= 1'b0;
      LIGHT:   out_stall <= ($urandom_range(3) == 0);
      HEAVY:   out_stall <= ($urandom_range(3) != 0);
      default: out_stall <= (stall_left % 7) < 3;
    endcase
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_reply({status, out_index, out_generation, found_callback, found_user_word});
  end

  // Sends one request in the current burst, opening a new burst with a gap of
  // random length once the old one is used up.
  task automatic send_request(logic [1:0] cmd, logic [31:0] idx, logic [31:0] gen,
                              logic [31:0] cb, logic [31:0] uw);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 5);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid          <= 1'b1;
    command           <= cmd;
    handle_index      <= idx;
    handle_generation <= gen;
    callback_ref      <= cb;
    user_word         <= uw;
    do @(posedge clk); while (in_stall);
    sb.take_request(cmd, idx, gen, cb, uw);
  endtask

  task automatic wait_for_replies();
    in_valid <= 1'b0;
    burst_left = 0;
    while (sb.replies_due.size() != 0) @(posedge clk);
  endtask

  // Most unregisters and lookups carry a live handle so that slots really get
  // recycled; the rest are stale, small or wholly random handles.
  task automatic random_request(int reg_pct);
    logic [1:0]  cmd;
    logic [31:0] idx;
    logic [31:0] gen;
    logic [31:0] cb;
    logic [31:0] uw;
    int          roll;
    int          slot;
    cb  = $urandom;
    uw  = $urandom;
    idx = $urandom;
    gen = $urandom;
    if ($urandom_range(19) == 0) cb = '0;
    if ($urandom_range(39) == 0) cb = '1;
    if ($urandom_range(99) < reg_pct) begin
      cmd = CMD_REGISTER;
    end else begin
      cmd = $urandom_range(1) ? CMD_UNREGISTER : CMD_LOOKUP;
      if ($urandom_range(29) == 0) cmd = CMD_UNDEFINED;
      roll = $urandom_range(99);
      if (roll < 70 && sb.pick_live(slot)) begin
        idx = slot;
        gen = sb.gen_of[slot];
      end else if (roll < 85 && sb.ever_used > 0) begin
        slot = $urandom_range(sb.ever_used - 1);
        idx = slot;
        gen = sb.gen_of[slot] - 32'($urandom_range(1));
      end else if (roll < 92) begin
        idx = $urandom_range(SLOT_COUNT - 1);
        gen = $urandom_range(2);
      end
    end
    send_request(cmd, idx, gen, cb, uw);
  endtask

  initial begin
    int sent;
    int phase_len;
    int reg_pct;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // From empty: lookups miss, a null callback fails, two registers succeed.
    send_request(CMD_LOOKUP, 32'd0, 32'd0, 32'd0, 32'd0);
    send_request(CMD_UNREGISTER, 32'd0, 32'd1, 32'd0, 32'd0);
    send_request(CMD_REGISTER, 32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF);
    send_request(CMD_REGISTER, '1, '1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(CMD_REGISTER, 32'd0, 32'd0, 32'd1, 32'd0);
    send_request(CMD_LOOKUP, 32'd0, 32'd1, 32'd0, 32'd0);
    send_request(CMD_LOOKUP, 32'd1, 32'd1, 32'd0, 32'd0);
    // Handle zero, an index past the used slots, the largest handle and a
    // wrong generation must all miss.
    send_request(CMD_LOOKUP, 32'd0, 32'd0, 32'd0, 32'd0);
    send_request(CMD_LOOKUP, 32'd2, 32'd1, 32'd0, 32'd0);
    send_request(CMD_LOOKUP, '1, '1, 32'd0, 32'd0);
    send_request(CMD_LOOKUP, 32'd0, 32'd2, 32'd0, 32'd0);
    send_request(CMD_UNDEFINED, 32'd0, 32'd1, 32'h1234_5678, 32'd7);
    // Freeing a slot moves its generation on, so the old handle dies.
    send_request(CMD_UNREGISTER, 32'd0, 32'd1, 32'd0, 32'd0);
    send_request(CMD_UNREGISTER, 32'd0, 32'd1, 32'd0, 32'd0);
    send_request(CMD_LOOKUP, 32'd0, 32'd1, 32'd0, 32'd0);
    send_request(CMD_LOOKUP, 32'd0, 32'd2, 32'd0, 32'd0);
    send_request(CMD_REGISTER, 32'd0, 32'd0, 32'hA5A5_A5A5, 32'h5A5A_5A5A);
    send_request(CMD_LOOKUP, 32'd0, 32'd2, 32'd0, 32'd0);
    // Freed slots come back last in, first out.
    send_request(CMD_UNREGISTER, 32'd1, 32'd1, 32'd0, 32'd0);
    send_request(CMD_UNREGISTER, 32'd0, 32'd2, 32'd0, 32'd0);
    send_request(CMD_REGISTER, 32'd0, 32'd0, 32'h0000_0002, 32'h8000_0000);
    send_request(CMD_REGISTER, 32'd0, 32'd0, 32'h8000_0000, 32'h0000_0001);
    send_request(CMD_LOOKUP, 32'd1, 32'd2, 32'd0, 32'd0);
    wait_for_replies();

    // The first phase leans hard on register so that the table fills up.
    sent = 0;
    reg_pct = 90;
    while (sent < RANDOM_REQUESTS) begin
      phase_len = $urandom_range(40, 100);
      for (int n = 0; n < phase_len && sent < RANDOM_REQUESTS; n++) begin
        random_request(reg_pct);
        sent++;
      end
      if ($urandom_range(1) == 0) wait_for_replies();
      case ($urandom_range(2))
        0:       reg_pct = 85;
        1:       reg_pct = 50;
        default: reg_pct = 20;
      endcase
    end

    in_valid <= 1'b0;
    for (int n = 0; n < 20000 && sb.replies_due.size() != 0; n++) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.replies_due.size() != 0)
      sb.report_mismatch($sformatf("%0d replies never arrived", sb.replies_due.size()));
    if (sb.errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
